/* sv/mmk_pkg.sv */
// Package for the Morse message keyer: types, constants, code table.
package mmk_pkg;

    localparam int MSG_DEPTH = 64;
    localparam int AW = $clog2(MSG_DEPTH);
    localparam int LW = $clog2(MSG_DEPTH + 1);

    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_CLEAR  = 2'd1;
    localparam logic [1:0] KIND_START  = 2'd2;
    localparam logic [1:0] KIND_TICK   = 2'd3;

    typedef enum logic [2:0] {
        SQ_IDLE     = 3'd0,
        SQ_PREAMBLE = 3'd1,
        SQ_ELEMENT  = 3'd2,
        SQ_ELEM_GAP = 3'd3,
        SQ_CHAR_GAP = 3'd4,
        SQ_WORD_GAP = 3'd5,
        SQ_TAIL     = 3'd6
    } t_seq;

    typedef enum logic [2:0] {
        CT_IDLE,
        CT_DIV,
        CT_SCAN_RD,
        CT_SCAN_CHK,
        CT_OUT
    } t_ctl;

    typedef struct packed {
        logic [2:0] len;
        logic [6:0] bits;
    } t_code;

    function automatic t_code code_of(input logic [7:0] c);
        t_code r;
        r = '{len: 3'd0, bits: 7'd0};
        case (c)
            "A": r = '{3'd2, 7'b0000010};
            "B": r = '{3'd4, 7'b0000001};
            "C": r = '{3'd4, 7'b0000101};
            "D": r = '{3'd3, 7'b0000001};
            "E": r = '{3'd1, 7'b0000000};
            "F": r = '{3'd4, 7'b0000100};
            "G": r = '{3'd3, 7'b0000011};
            "H": r = '{3'd4, 7'b0000000};
            "I": r = '{3'd2, 7'b0000000};
            "J": r = '{3'd4, 7'b0001110};
            "K": r = '{3'd3, 7'b0000101};
            "L": r = '{3'd4, 7'b0000010};
            "M": r = '{3'd2, 7'b0000011};
            "N": r = '{3'd2, 7'b0000001};
            "O": r = '{3'd3, 7'b0000111};
            "P": r = '{3'd4, 7'b0000110};
            "Q": r = '{3'd4, 7'b0001011};
            "R": r = '{3'd3, 7'b0000010};
            "S": r = '{3'd3, 7'b0000000};
            "T": r = '{3'd1, 7'b0000001};
            "U": r = '{3'd3, 7'b0000100};
            "V": r = '{3'd4, 7'b0001000};
            "W": r = '{3'd3, 7'b0000110};
            "X": r = '{3'd4, 7'b0001001};
            "Y": r = '{3'd4, 7'b0001101};
            "Z": r = '{3'd4, 7'b0000011};
            "0": r = '{3'd5, 7'b0011111};
            "1": r = '{3'd5, 7'b0011110};
            "2": r = '{3'd5, 7'b0011100};
            "3": r = '{3'd5, 7'b0011000};
            "4": r = '{3'd5, 7'b0010000};
            "5": r = '{3'd5, 7'b0000000};
            "6": r = '{3'd5, 7'b0000001};
            "7": r = '{3'd5, 7'b0000011};
            "8": r = '{3'd5, 7'b0000111};
            "9": r = '{3'd5, 7'b0001111};
            ".": r = '{3'd6, 7'b0101010};
            ",": r = '{3'd6, 7'b0110011};
            "?": r = '{3'd6, 7'b0001100};
            "'": r = '{3'd6, 7'b0011110};
            "!": r = '{3'd6, 7'b0110101};
            "/": r = '{3'd5, 7'b0001001};
            "(": r = '{3'd5, 7'b0001101};
            ")": r = '{3'd6, 7'b0101101};
            "&": r = '{3'd5, 7'b0000010};
            ":": r = '{3'd6, 7'b0000111};
            ";": r = '{3'd6, 7'b0010101};
            "=": r = '{3'd5, 7'b0010001};
            "+": r = '{3'd5, 7'b0001010};
            "-": r = '{3'd6, 7'b0100001};
            "_": r = '{3'd6, 7'b0101100};
            8'h22: r = '{3'd6, 7'b0010010};
            "$": r = '{3'd7, 7'b1001000};
            "@": r = '{3'd6, 7'b0010110};
            default: r = '{3'd0, 7'b0000000};
        endcase
        return r;
    endfunction

endpackage

/* sv/mmk_ram.sv */
// Generic single-port RAM with registered read.
module mmk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

/* sv/mmk_div.sv */
// Restoring divider: dit length in ms from 1200 / wpm, one quotient bit a cycle.
module mmk_div (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [5:0] i_wpm,
    output logic       o_done,
    output logic [7:0] o_dit_ms
);
    logic [10:0] r_rem;
    logic [10:0] r_quo;
    logic [3:0]  r_cnt;
    logic        r_busy;
    logic [10:0] n_rem;
    logic [11:0] trial;
    logic [10:0] dit;

    localparam logic [10:0] DIVIDEND = 11'd1200;

    always_comb begin
        n_rem = {r_rem[9:0], DIVIDEND[r_cnt]};
        trial = {1'b0, n_rem} - {6'd0, i_wpm};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= r_busy && (r_cnt == 4'd0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd10;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                if (!trial[11]) begin
                    r_rem <= trial[10:0];
                    r_quo <= {r_quo[9:0], 1'b1};
                end else begin
                    r_rem <= n_rem;
                    r_quo <= {r_quo[9:0], 1'b0};
                end
                if (r_cnt == 4'd0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 4'd1;
                end
            end
        end
    end

    // speed 0 gives the longest dit; clamp to 20..240
    always_comb begin
        if (i_wpm == 6'd0 || r_quo > 11'd240) begin
            dit = 11'd240;
        end else if (r_quo < 11'd20) begin
            dit = 11'd20;
        end else begin
            dit = r_quo;
        end
        o_dit_ms = dit[7:0];
    end
endmodule

/* sv/morse_message_keyer.sv */
// Morse message keyer top level.
// Each input item is worked on in turn; the block holds o_stall high while working.
// Append, clear, rejected commands and ticks that need no scan pass through
// accept and result. An accepted start runs a bit-serial divide of 1200 by
// the speed and waits to see it done. A tick that scans stored characters
// reads each character from the single-port message RAM and then checks it,
// until one sends or the store ends. One result word leaves per input word;
// o_stall stays high while a result waits. No clearing pass after reset.
module morse_message_keyer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_char_code,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_tone_on,
    output logic       o_sending,
    output logic       o_finished,
    output logic       o_accepted,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [5:0] i_cfg_data
);
    import mmk_pkg::*;

    t_ctl r_ctl, n_ctl;
    t_seq r_seq;
    logic [5:0] r_wpm;
    logic [LW-1:0] r_len, r_rd;
    logic [6:0] r_pbits;
    logic [2:0] r_plen, r_eidx;
    logic [7:0] r_wait;
    logic r_lsp, r_sent, r_tone, r_fin, r_acc;
    logic [7:0] r_tdit, r_tdah, r_tword;

    logic ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0] ram_q, cu;
    logic div_start, div_done;
    logic [7:0] dit_ms;
    logic [11:0] ms3, ms7;
    t_code code;
    logic tick_now, scan_now, fin_now, acc_now;
    logic [LW-1:0] rd_next;
    logic word_gap, scan_hit;

    // (ms + 5) / 10 by reciprocal multiply, exact over the clamped range
    function automatic logic [7:0] ms_to_ticks(input logic [11:0] ms);
        logic [24:0] p;
        p = ({13'd0, ms} + 25'd5) * 25'd6554;
        return p[23:16];
    endfunction

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpm <= 6'd20;
        end else if (i_cfg_valid) begin
            r_wpm <= i_cfg_data;
        end
    end

    assign o_stall = (r_ctl != CT_IDLE);
    assign o_valid = (r_ctl == CT_OUT);
    assign o_tone_on = r_tone;
    assign o_sending = (r_seq != SQ_IDLE);
    assign o_finished = r_fin;
    assign o_accepted = r_acc;

    assign ram_we = (r_ctl == CT_IDLE) && i_valid && i_kind == KIND_APPEND
                    && r_seq == SQ_IDLE && r_len < LW'(MSG_DEPTH);
    assign ram_addr = ram_we ? r_len[AW-1:0] : r_rd[AW-1:0];
    assign div_start = (r_ctl == CT_IDLE) && i_valid && i_kind == KIND_START
                       && r_seq == SQ_IDLE && r_len != '0;

    assign tick_now = i_valid && i_kind == KIND_TICK && r_seq != SQ_IDLE && r_wait == '0;
    assign scan_now = tick_now && (r_seq inside {SQ_PREAMBLE, SQ_ELEMENT})
                      && (r_plen == '0 || r_eidx >= r_plen);
    assign fin_now = tick_now && r_seq == SQ_TAIL;
    assign acc_now = ram_we || div_start
                     || (i_valid && i_kind == KIND_CLEAR && r_seq == SQ_IDLE);

    mmk_ram #(.WIDTH(8), .DEPTH(MSG_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(i_char_code), .o_rdata(ram_q)
    );

    mmk_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_wpm(r_wpm), .o_done(div_done), .o_dit_ms(dit_ms)
    );

    assign ms3 = {4'd0, dit_ms} * 12'd3;
    assign ms7 = {4'd0, dit_ms} * 12'd7;
    assign cu = (ram_q >= "a" && ram_q <= "z") ? ram_q - 8'd32 : ram_q;
    assign code = code_of(cu);

    assign rd_next = r_rd + 1'b1;
    // a space keys a word gap only after a sent character, not after another gap, and not as the last stored byte
    assign word_gap = r_sent && !r_lsp && rd_next < r_len;
    assign scan_hit = (cu == " ") ? word_gap : (code.len != '0);

    always_comb begin
        n_ctl = r_ctl;
        case (r_ctl)
            CT_IDLE: begin
                if (div_start) begin
                    n_ctl = CT_DIV;
                end else if (scan_now) begin
                    n_ctl = CT_SCAN_RD;
                end else if (i_valid) begin
                    n_ctl = CT_OUT;
                end
            end
            CT_DIV: if (div_done) n_ctl = CT_OUT;
            CT_SCAN_RD: n_ctl = (r_rd >= r_len) ? CT_OUT : CT_SCAN_CHK;
            CT_SCAN_CHK: n_ctl = scan_hit ? CT_OUT : CT_SCAN_RD;
            CT_OUT: if (!i_stall) n_ctl = CT_IDLE;
            default: n_ctl = CT_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= CT_IDLE;
            r_seq <= SQ_IDLE;
            r_len <= '0; r_rd <= '0; r_pbits <= '0; r_plen <= '0; r_eidx <= '0;
            r_wait <= '0; r_lsp <= 1'b0; r_sent <= 1'b0; r_tone <= 1'b0;
            r_fin <= 1'b0; r_acc <= 1'b0;
            r_tdit <= '0; r_tdah <= '0; r_tword <= '0;
        end else begin
            r_ctl <= n_ctl;
            case (r_ctl)
                CT_IDLE: if (i_valid) begin
                    r_fin <= fin_now;
                    r_acc <= acc_now;
                    case (i_kind)
                        KIND_APPEND: if (ram_we) begin
                            r_len <= r_len + 1'b1;
                        end
                        KIND_CLEAR: if (r_seq == SQ_IDLE) begin
                            r_len <= '0;
                        end
                        KIND_START: if (div_start) begin
                            r_seq <= SQ_PREAMBLE;
                            r_rd <= '0; r_pbits <= '0; r_plen <= '0; r_eidx <= '0;
                            r_wait <= 8'd5; r_lsp <= 1'b0; r_sent <= 1'b0;
                        end
                        default: begin
                            // tick
                            if (r_seq != SQ_IDLE) begin
                                if (r_wait != '0) begin
                                    r_wait <= r_wait - 8'd1;
                                end else begin
                                    case (r_seq)
                                        SQ_PREAMBLE, SQ_ELEMENT: begin
                                            if (r_plen == '0 || r_eidx >= r_plen) begin
                                                r_seq <= SQ_ELEMENT;
                                                r_plen <= '0;
                                            end else begin
                                                r_tone <= 1'b1;
                                                r_wait <= r_pbits[r_eidx] ? r_tdah : r_tdit;
                                                r_seq <= SQ_ELEM_GAP;
                                            end
                                        end
                                        SQ_ELEM_GAP: begin
                                            r_tone <= 1'b0;
                                            r_eidx <= r_eidx + 3'd1;
                                            if (r_eidx + 3'd1 < r_plen && r_eidx != 3'd7) begin
                                                r_seq <= SQ_ELEMENT;
                                                r_wait <= r_tdit;
                                            end else begin
                                                r_seq <= SQ_CHAR_GAP;
                                                r_wait <= r_tdah;
                                            end
                                        end
                                        SQ_CHAR_GAP, SQ_WORD_GAP: r_seq <= SQ_ELEMENT;
                                        SQ_TAIL: begin
                                            r_seq <= SQ_IDLE;
                                            r_wait <= '0;
                                            r_tone <= 1'b0;
                                        end
                                        default: r_seq <= SQ_IDLE;
                                    endcase
                                end
                            end
                        end
                    endcase
                end
                CT_DIV: if (div_done) begin
                    r_tdit  <= ms_to_ticks({4'd0, dit_ms});
                    r_tdah  <= ms_to_ticks(ms3);
                    r_tword <= ms_to_ticks(ms7);
                end
                CT_SCAN_RD: begin
                    if (r_rd >= r_len) begin
                        // message exhausted
                        r_seq <= SQ_TAIL;
                        r_wait <= r_tdah;
                    end
                end
                CT_SCAN_CHK: begin
                    r_rd <= rd_next;
                    if (cu == " ") begin
                        if (word_gap) begin
                            r_lsp <= 1'b1;
                            r_seq <= SQ_WORD_GAP;
                            r_wait <= r_tword;
                        end
                    end else if (code.len != '0) begin
                        r_plen <= code.len;
                        r_pbits <= code.bits;
                        r_eidx <= '0;
                        r_sent <= 1'b1;
                        r_lsp <= 1'b0;
                        r_tone <= 1'b1;
                        r_wait <= code.bits[0] ? r_tdah : r_tdit;
                        r_seq <= SQ_ELEM_GAP;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the Morse message keyer top level.
`timescale 1ns / 1ps

module tb_top;
    import mmk_pkg::*;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] chr;
    } t_word;

    typedef struct packed {
        logic tone;
        logic sending;
        logic finished;
        logic accepted;
    } t_result;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 300;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [1:0] i_kind = KIND_TICK;
    logic [7:0] i_char_code = 8'd0;
    logic       i_stall = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [5:0] i_cfg_data = 6'd0;
    logic       o_stall, o_valid, o_tone_on, o_sending, o_finished, o_accepted;
    logic       o_cfg_ready;

    morse_message_keyer u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_kind(i_kind), .i_char_code(i_char_code),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_tone_on(o_tone_on), .o_sending(o_sending),
        .o_finished(o_finished), .o_accepted(o_accepted),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    t_word   word_q[$];
    t_result keyer_out_q[$];
    int      mismatches = 0;
    int      items = 0;

    // Keyer model state
    logic [5:0] kp_wpm;
    logic [7:0] kp_store[MSG_DEPTH];
    int         kp_len, kp_rd, kp_plen, kp_eidx;
    t_seq       kp_seq;
    logic [6:0] kp_bits;
    logic [7:0] kp_wait;
    logic       kp_space, kp_sent, kp_tone;
    logic [7:0] kp_dit, kp_dah, kp_cgap, kp_wgap;

    function automatic string morse_text(input logic [7:0] c);
        case (c)
            "A": return ".-";    "B": return "-...";  "C": return "-.-.";
            "D": return "-..";   "E": return ".";     "F": return "..-.";
            "G": return "--.";   "H": return "....";  "I": return "..";
            "J": return ".---";  "K": return "-.-";   "L": return ".-..";
            "M": return "--";    "N": return "-.";    "O": return "---";
            "P": return ".--.";  "Q": return "--.-";  "R": return ".-.";
            "S": return "...";   "T": return "-";     "U": return "..-";
            "V": return "...-";  "W": return ".--";   "X": return "-..-";
            "Y": return "-.--";  "Z": return "--..";
            "0": return "-----"; "1": return ".----"; "2": return "..---";
            "3": return "...--"; "4": return "....-"; "5": return ".....";
            "6": return "-...."; "7": return "--..."; "8": return "---..";
            "9": return "----.";
            ".": return ".-.-.-"; ",": return "--..--"; "?": return "..--..";
            "'": return ".----."; "!": return "-.-.--"; "/": return "-..-.";
            "(": return "-.--.";  ")": return "-.--.-"; "&": return ".-...";
            ":": return "---..."; ";": return "-.-.-."; "=": return "-...-";
            "+": return ".-.-.";  "-": return "-....-"; "_": return "..--.-";
            8'h22: return ".-..-."; "$": return "...-..-"; "@": return ".--.-.";
            default: return "";
        endcase
    endfunction

    function automatic logic [7:0] ms_to_ticks(input int ms);
        return 8'((ms + 5) / 10);
    endfunction

    function automatic void keyer_reset();
        kp_wpm = 6'd20;
        kp_len = 0; kp_rd = 0; kp_plen = 0; kp_eidx = 0;
        kp_seq = SQ_IDLE; kp_bits = '0; kp_wait = '0;
        kp_space = 0; kp_sent = 0; kp_tone = 0;
        kp_dit = 0; kp_dah = 0; kp_cgap = 0; kp_wgap = 0;
    endfunction

    // one tick of the keying sequence; returns 1 when the tail ends
    function automatic logic keyer_tick();
        logic [7:0] c;
        string s;
        if (kp_wait > 0) begin
            kp_wait--;
            return 1'b0;
        end
        case (kp_seq)
            SQ_PREAMBLE, SQ_ELEMENT: begin
                kp_seq = SQ_ELEMENT;
                if (kp_plen == 0 || kp_eidx >= kp_plen) begin
                    kp_plen = 0;
                    while (kp_rd < kp_len) begin
                        c = kp_store[kp_rd];
                        if (c >= "a" && c <= "z") c = c - 8'd32;
                        if (c == " ") begin
                            kp_rd++;
                            if (!kp_sent || kp_space || kp_rd >= kp_len) continue;
                            kp_space = 1;
                            kp_seq = SQ_WORD_GAP;
                            kp_wait = kp_wgap;
                            return 1'b0;
                        end
                        s = morse_text(c);
                        kp_plen = s.len();
                        kp_bits = '0;
                        for (int k = 0; k < s.len(); k++)
                            if (s[k] == "-") kp_bits[k] = 1'b1;
                        kp_eidx = 0;
                        kp_rd++;
                        if (kp_plen != 0) begin
                            kp_sent = 1;
                            kp_space = 0;
                            break;
                        end
                    end
                    if (kp_plen == 0) begin
                        kp_seq = SQ_TAIL;
                        kp_wait = kp_cgap;
                        return 1'b0;
                    end
                end
                kp_tone = 1;
                kp_wait = kp_bits[kp_eidx] ? kp_dah : kp_dit;
                kp_seq = SQ_ELEM_GAP;
                return 1'b0;
            end
            SQ_ELEM_GAP: begin
                kp_tone = 0;
                kp_eidx++;
                if (kp_eidx < kp_plen) begin
                    kp_seq = SQ_ELEMENT;
                    kp_wait = kp_dit;
                end else begin
                    kp_seq = SQ_CHAR_GAP;
                    kp_wait = kp_cgap;
                end
                return 1'b0;
            end
            SQ_CHAR_GAP, SQ_WORD_GAP: begin
                kp_seq = SQ_ELEMENT;
                return 1'b0;
            end
            SQ_TAIL: begin
                kp_seq = SQ_IDLE;
                kp_wait = 0;
                kp_tone = 0;
                return 1'b1;
            end
            default: begin
                kp_seq = SQ_IDLE;
                return 1'b0;
            end
        endcase
    endfunction

    // queue one word and the keyer output it must produce
    task automatic send_word(input logic [1:0] kind, input logic [7:0] chr);
        logic busy, acc, fin;
        int dit;
        busy = (kp_seq != SQ_IDLE);
        acc = 0;
        fin = 0;
        case (kind)
            KIND_APPEND: if (!busy && kp_len < MSG_DEPTH) begin
                kp_store[kp_len] = chr;
                kp_len++;
                acc = 1;
            end
            KIND_CLEAR: if (!busy) begin
                kp_len = 0;
                acc = 1;
            end
            KIND_START: if (!busy && kp_len > 0) begin
                dit = (kp_wpm == 0) ? 240 : 1200 / kp_wpm;
                if (dit < 20) dit = 20;
                if (dit > 240) dit = 240;
                kp_dit = ms_to_ticks(dit);
                kp_dah = ms_to_ticks(dit * 3);
                kp_cgap = ms_to_ticks(dit * 3);
                kp_wgap = ms_to_ticks(dit * 7);
                kp_seq = SQ_PREAMBLE;
                kp_rd = 0; kp_bits = 0; kp_plen = 0; kp_eidx = 0;
                kp_wait = 8'd5;
                kp_space = 0; kp_sent = 0;
                acc = 1;
            end
            default: if (busy) fin = keyer_tick();
        endcase
        word_q.push_back('{kind, chr});
        keyer_out_q.push_back('{kp_tone, kp_seq != SQ_IDLE, fin, acc});
        items++;
    endtask

    task automatic wait_drained();
        while (word_q.size() != 0 || keyer_out_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_speed(input logic [5:0] wpm);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= wpm;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        i_cfg_data <= 6'($urandom);
        kp_wpm = wpm;
    endtask

    function automatic logic [7:0] rand_char();
        string punct;
        punct = ".,?'!/()&:;=+-_\"$@";
        case ($urandom_range(0, 9))
            0, 1, 2: return 8'($urandom_range("A", "Z"));
            3, 4:    return 8'($urandom_range("a", "z"));
            5:       return 8'($urandom_range("0", "9"));
            6:       return " ";
            7:       return punct[$urandom_range(0, punct.len() - 1)];
            default: return 8'($urandom);
        endcase
    endfunction

    // ticks until the message ends, with rejected commands mixed in
    task automatic key_out(input int noise_pct);
        while (kp_seq != SQ_IDLE) begin
            if ($urandom_range(0, 99) < noise_pct)
                send_word(2'($urandom_range(0, 2)), 8'($urandom));
            else
                send_word(KIND_TICK, 8'($urandom));
        end
    endtask

    initial begin
        int n;
        keyer_reset();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty start, idle tick, odd bytes, spaces, longest code
        send_word(KIND_CLEAR, 8'hFF);
        send_word(KIND_START, 8'h00);
        send_word(KIND_TICK, 8'hA5);
        send_word(KIND_APPEND, " ");
        send_word(KIND_APPEND, "a");
        send_word(KIND_APPEND, " ");
        send_word(KIND_APPEND, " ");
        send_word(KIND_APPEND, 8'hFF);
        send_word(KIND_APPEND, 8'h00);
        send_word(KIND_APPEND, "$");
        send_word(KIND_APPEND, "z");
        send_word(KIND_APPEND, " ");
        send_word(KIND_START, 8'h5A);
        send_word(KIND_APPEND, "E");
        send_word(KIND_CLEAR, 8'h00);
        send_word(KIND_START, 8'hFF);
        key_out(0);
        write_speed(6'd63);
        send_word(KIND_START, 8'h00);
        key_out(0);
        write_speed(6'd0);
        send_word(KIND_CLEAR, 8'h00);
        send_word(KIND_APPEND, "T");
        send_word(KIND_START, 8'h00);
        key_out(0);
        write_speed(6'd1);
        send_word(KIND_START, 8'h00);
        key_out(0);

        while (items < 1850) begin
            case ($urandom_range(0, 19))
                0: write_speed(6'($urandom_range(1, 12)));
                1, 2: write_speed(6'($urandom_range(30, 63)));
                3: begin
                    // overfill the store, mostly with bytes that send nothing;
                    // real characters only at speeds that key them quickly
                    send_word(KIND_CLEAR, 8'($urandom));
                    for (int k = 0; k < MSG_DEPTH + 3; k++)
                        send_word(KIND_APPEND,
                                  (kp_wpm >= 20 && $urandom_range(0, 15) == 0) ? rand_char()
                                  : (($urandom_range(0, 1) != 0) ? " "
                                  : 8'($urandom_range(128, 255))));
                    send_word(KIND_START, 8'($urandom));
                    key_out(5);
                end
                4: send_word(2'($urandom), 8'($urandom));
                5: begin
                    // hold off until the keyer has caught up
                    wait_drained();
                    send_word(KIND_CLEAR, 8'($urandom));
                end
                default: begin
                    if ($urandom_range(0, 3) != 0) send_word(KIND_CLEAR, 8'($urandom));
                    n = (kp_wpm < 20) ? $urandom_range(1, 2) : $urandom_range(1, 6);
                    for (int k = 0; k < n; k++) send_word(KIND_APPEND, rand_char());
                    send_word(KIND_START, 8'($urandom));
                    key_out($urandom_range(0, 10));
                end
            endcase
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("morse_message_keyer test passed");
        else
            $display("morse_message_keyer test failed");
        $finish;
    end

    // word driver: bursts with random gaps
    logic in_took = 1'b0;
    int   burst_left = 0, gap_left = 0;

    always @(posedge i_clk) in_took <= i_rst_n && i_valid && !o_stall;

    always @(negedge i_clk) begin
        if (in_took) void'(word_q.pop_front());
        if (!i_valid || in_took) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (word_q.size() != 0 && i_rst_n) begin
                i_valid <= 1'b1;
                i_kind <= word_q[0].kind;
                i_char_code <= word_q[0].chr;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result stall pattern: one of four randomly drawn modes drives i_stall
    int stall_mode = 0, stall_cnt = 0;

    always @(negedge i_clk) begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt % 128 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 1) != 0);
            2: i_stall <= (stall_cnt % 16) < 11;
            default: i_stall <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // result checker and watchdog
    int quiet = 0;

    always @(posedge i_clk) begin
        t_result want, got;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_tone_on, o_sending, o_finished, o_accepted};
            if (keyer_out_q.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected result word %b", got);
            end else begin
                want = keyer_out_q.pop_front();
                if (got !== want) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch tone/sending/finished/accepted: exp %b got %b",
                                 want, got);
                end
            end
        end
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("morse_message_keyer test failed");
            $finish;
        end
    end

endmodule
